@@ src/gsms_pkg.sv @@
// ----------------------------------------------------------------------------
// gsms_pkg
// Shared types and constants for the gauge stepper microstep sequencer.
// ----------------------------------------------------------------------------
package gsms_pkg;

    // Number of channels that carry limit registers (fixed by the register map).
    localparam int REG_CHANNELS = 4;

    // Register map: zero offsets first, then maximum positions.
    localparam int CFG_IDX_W             = 3;
    localparam int CFG_DATA_W            = 16;
    localparam int CFG_ZERO_OFFSET_BASE  = 0;
    localparam int CFG_MAX_POSITION_BASE = 4;

    localparam logic signed [15:0] ZERO_OFFSET_RST  = 16'sd0;
    localparam logic signed [15:0] MAX_POSITION_RST = 16'sd32767;

    typedef struct packed {
        logic [1:0]         channel;
        logic signed [15:0] target;
        logic               move_enable;
        logic               startup_mode;
        logic [14:0]        reload;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         out_channel;
        logic               stepped;
        logic [6:0]         phase_index;
        logic signed [15:0] position;
        logic [15:0]        steps_taken;
    } t_out_beat;

    // Per-channel state as held in the state memory.
    typedef struct packed {
        logic [15:0]        cnt;
        logic signed [7:0]  ph;
        logic signed [15:0] cd;
        logic signed [15:0] pos;
    } t_state;

    localparam int STATE_W = $bits(t_state);

    localparam t_state STATE_RST = '{
        cnt: 16'd0,
        ph:  -8'sd1,
        cd:  16'sd0,
        pos: 16'sd0
    };

endpackage

@@ src/gauge_stepper_microstep_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// gauge_stepper_microstep_sequencer_unit
// Per-channel microstep sequencer for gauge stepper motors, with the channel
// state held in a small synchronous memory.
// ----------------------------------------------------------------------------
// A result beat passes through the stage 1 register and the output register.
// Throughput: one beat per cycle while the output is not stalled, set by the
// single read-modify-write pass over the state memory (one read port, one
// write port, registered read). Back-to-back beats on the same channel are
// served by forwarding the value being written back, so no interlock bubble.
// Reset: synchronous, active low; the limit registers return to their reset
// values and every channel reads as its reset state at once (valid bits).
// ----------------------------------------------------------------------------
module gauge_stepper_microstep_sequencer_unit #(
    parameter int NUM_CHANNELS = 4,
    parameter int PHASE_COUNT  = 64,
    parameter int SKIP_AMOUNT  = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  gsms_pkg::t_in_beat                  i_in_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output gsms_pkg::t_out_beat                 o_out_beat,
    input  logic                                i_cfg_we,
    input  logic [gsms_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gsms_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Limit registers: the user writes them only while the block is idle; the block itself does not enforce this.
    logic signed [15:0] r_zero_offset [gsms_pkg::REG_CHANNELS];
    logic signed [15:0] r_max_position [gsms_pkg::REG_CHANNELS];

    // Per-channel valid bits: a channel that has never been written back
    // reads as its reset state rather than the memory contents.
    logic [NUM_CHANNELS-1:0] r_vld;

    // Stage 1: the beat whose state is being read from the memory.
    logic                 r_s1_valid;
    gsms_pkg::t_in_beat   r_s1_beat;
    logic                 r_s1_vld;
    logic                 r_s1_fwd;
    gsms_pkg::t_state     r_s1_fwd_data;

    // Output register.
    logic                 r_out_valid;
    gsms_pkg::t_out_beat  r_out_beat;

    logic                 w_accept;
    logic                 w_s1_go;
    logic [AW+1:0]        w_in_ch_ext;
    logic [AW+1:0]        w_s1_ch_ext;
    logic [AW-1:0]        w_rd_addr;
    logic [AW-1:0]        w_wr_addr;
    logic                 w_in_ch_ok;
    logic                 w_s1_ch_ok;
    logic                 w_wr_en;
    logic [gsms_pkg::STATE_W-1:0] w_ram_rdata;
    gsms_pkg::t_state     w_cur;
    gsms_pkg::t_state     w_next;
    logic                 w_stepped;
    gsms_pkg::t_out_beat  w_out_beat;

    // Stage 1 moves on whenever the output register is empty or being
    // emptied; the input side takes a beat whenever stage 1 is empty or free to move.
    assign w_s1_go    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_s1_go;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_in_ch_ext = (AW + 2)'(i_in_beat.channel);
    assign w_s1_ch_ext = (AW + 2)'(r_s1_beat.channel);
    assign w_rd_addr   = w_in_ch_ext[AW-1:0];
    assign w_wr_addr   = w_s1_ch_ext[AW-1:0];
    assign w_in_ch_ok  = int'(i_in_beat.channel) < NUM_CHANNELS;
    assign w_s1_ch_ok  = int'(r_s1_beat.channel) < NUM_CHANNELS;

    // The write-back happens as stage 1 hands its result on. A channel that
    // is out of range leaves all state untouched.
    assign w_wr_en = r_s1_valid && w_s1_go && w_s1_ch_ok;

    gsms_ram #(
        .WIDTH (gsms_pkg::STATE_W),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_next),
        .i_re    (w_accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    // The memory read issued for a beat misses a write-back to the same
    // channel that lands on the same edge; that value is captured and used
    // in place of the read data.
    always_comb begin
        if (r_s1_fwd) begin
            w_cur = r_s1_fwd_data;
        end else if (r_s1_vld) begin
            w_cur = gsms_pkg::t_state'(w_ram_rdata);
        end else begin
            w_cur = gsms_pkg::STATE_RST;
        end
    end

    gsms_step #(
        .PHASE_COUNT (PHASE_COUNT),
        .SKIP_AMOUNT (SKIP_AMOUNT)
    ) u_step (
        .i_beat         (r_s1_beat),
        .i_cur          (w_cur),
        .i_zero_offset  (r_zero_offset[r_s1_beat.channel]),
        .i_max_position (r_max_position[r_s1_beat.channel]),
        .o_next         (w_next),
        .o_stepped      (w_stepped)
    );

    // An out-of-range channel echoes its number and reports zeros elsewhere.
    always_comb begin
        w_out_beat.out_channel = r_s1_beat.channel;
        if (w_s1_ch_ok) begin
            w_out_beat.stepped     = w_stepped;
            w_out_beat.phase_index = w_next.ph[6:0];
            w_out_beat.position    = w_next.pos;
            w_out_beat.steps_taken = w_next.cnt;
        end else begin
            w_out_beat.stepped     = 1'b0;
            w_out_beat.phase_index = 7'd0;
            w_out_beat.position    = 16'sd0;
            w_out_beat.steps_taken = 16'd0;
        end
    end

    // Configuration registers. Indices 0 to 3 select a zero offset and
    // 4 to 7 a maximum position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gsms_pkg::REG_CHANNELS; i++) begin
                r_zero_offset[i]  <= gsms_pkg::ZERO_OFFSET_RST;
                r_max_position[i] <= gsms_pkg::MAX_POSITION_RST;
            end
        end else if (i_cfg_we) begin
            if (int'(i_cfg_idx) < gsms_pkg::CFG_MAX_POSITION_BASE) begin
                r_zero_offset[i_cfg_idx[1:0]] <= i_cfg_wdata;
            end else begin
                r_max_position[i_cfg_idx[1:0]] <= i_cfg_wdata;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_fwd    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_vld[w_wr_addr] <= 1'b1;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
                r_s1_fwd   <= w_accept && w_wr_en && (w_wr_addr == w_rd_addr);
            end
            if (w_s1_go) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_beat     <= i_in_beat;
            r_s1_vld      <= w_in_ch_ok ? r_vld[w_rd_addr] : 1'b0;
            r_s1_fwd_data <= w_next;
        end
        if (w_s1_go && r_s1_valid) begin
            r_out_beat <= w_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // A full stage 1 that cannot move must hold the input side off.
    a_no_accept_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_go) |-> !o_in_ready)
        else $error("input beat taken while stage 1 is blocked");

    // Forwarded data is only ever attached to a live beat.
    a_fwd_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> r_s1_valid)
        else $error("forwarding flag set with stage 1 empty");

    // A write-back marks its channel valid for every later read.
    a_wb_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> r_vld[$past(w_wr_addr)])
        else $error("valid bit not set after write-back");

    // A step can only be reported for a channel that exists.
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.stepped) |->
            (int'(o_out_beat.out_channel) < NUM_CHANNELS))
        else $error("step reported for an out-of-range channel");

endmodule

@@ src/gsms_ram.sv @@
// ----------------------------------------------------------------------------
// gsms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gsms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/gsms_step.sv @@
// ----------------------------------------------------------------------------
// gsms_step
// Next-state logic for one tick of one channel: countdown, step direction,
// phase wrap and position clamp.
// ----------------------------------------------------------------------------
module gsms_step #(
    parameter int PHASE_COUNT = 64,
    parameter int SKIP_AMOUNT = 4
) (
    input  gsms_pkg::t_in_beat  i_beat,
    input  gsms_pkg::t_state    i_cur,
    input  logic signed [15:0]  i_zero_offset,
    input  logic signed [15:0]  i_max_position,
    output gsms_pkg::t_state    o_next,
    output logic                o_stepped
);

    localparam logic signed [7:0] PH_WRAP_NORMAL  = 8'(PHASE_COUNT - 1);
    localparam logic signed [7:0] PH_WRAP_STARTUP = 8'(PHASE_COUNT - SKIP_AMOUNT + 1);

    logic               w_move;
    logic               w_down;
    logic signed [16:0] w_cd_dec;
    logic               w_expired;
    logic [7:0]         w_sz8;
    logic signed [16:0] w_sz17;
    logic signed [7:0]  w_ph_dn;
    logic signed [7:0]  w_ph_up;
    logic signed [16:0] w_pos_dn;
    logic signed [16:0] w_pos_up;
    logic signed [7:0]  w_ph_new;
    logic signed [15:0] w_pos_new;

    assign w_move    = i_beat.move_enable && (i_beat.target != i_cur.pos);
    assign w_down    = i_beat.target < i_cur.pos;
    assign w_cd_dec  = {i_cur.cd[15], i_cur.cd} - 17'sd1;
    assign w_expired = w_cd_dec[16] || (w_cd_dec == 17'sd0);

    assign w_sz8  = i_beat.startup_mode ? 8'(SKIP_AMOUNT) : 8'd1;
    assign w_sz17 = i_beat.startup_mode ? 17'(SKIP_AMOUNT) : 17'sd1;

    assign w_ph_dn  = i_cur.ph - w_sz8;
    assign w_ph_up  = i_cur.ph + w_sz8;
    assign w_pos_dn = {i_cur.pos[15], i_cur.pos} - w_sz17;
    assign w_pos_up = {i_cur.pos[15], i_cur.pos} + w_sz17;

    always_comb begin
        if (w_down) begin
            if (w_ph_dn[7]) begin
                w_ph_new = i_beat.startup_mode ? PH_WRAP_STARTUP : PH_WRAP_NORMAL;
            end else begin
                w_ph_new = w_ph_dn;
            end
            // Only the bound in the direction of travel applies.
            if (w_pos_dn < $signed({i_zero_offset[15], i_zero_offset})) begin
                w_pos_new = i_zero_offset;
            end else begin
                w_pos_new = w_pos_dn[15:0];
            end
        end else begin
            if (int'(w_ph_up) >= PHASE_COUNT) begin
                w_ph_new = 8'sd0;
            end else begin
                w_ph_new = w_ph_up;
            end
            if (w_pos_up > $signed({i_max_position[15], i_max_position})) begin
                w_pos_new = i_max_position;
            end else begin
                w_pos_new = w_pos_up[15:0];
            end
        end
    end

    always_comb begin
        o_next    = i_cur;
        o_stepped = 1'b0;
        if (w_move) begin
            if (w_expired) begin
                o_stepped  = 1'b1;
                o_next.cd  = {1'b0, i_beat.reload};
                o_next.ph  = w_ph_new;
                o_next.pos = w_pos_new;
                o_next.cnt = i_cur.cnt + 16'd1;
            end else begin
                o_next.cd = w_cd_dec[15:0];
            end
        end
    end

endmodule
